/* design/ctsc_pkg.sv */
// Shared types, RTC register codes and BCD helpers for the clock time-setting controller.
// No dependencies.
package ctsc_pkg;

	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);

	localparam logic [1:0] KIND_REFRESH = 2'd0;
	localparam logic [1:0] KIND_SET     = 2'd1;
	localparam logic [1:0] KIND_UP      = 2'd2;
	localparam logic [1:0] KIND_DOWN    = 2'd3;

	localparam logic [3:0] MODE_RUN  = 4'd0;
	localparam logic [3:0] MODE_SEC  = 4'd1;
	localparam logic [3:0] MODE_MIN  = 4'd2;
	localparam logic [3:0] MODE_HOUR = 4'd3;
	localparam logic [3:0] MODE_WDAY = 4'd4;
	localparam logic [3:0] MODE_DAY  = 4'd5;
	localparam logic [3:0] MODE_MON  = 4'd6;
	localparam logic [3:0] MODE_YEAR = 4'd7;
	localparam logic [3:0] MODE_DONE = 4'd8;

	localparam logic [7:0] ADDR_PROTECT = 8'h8e;
	localparam logic [7:0] ADDR_SEC     = 8'h80;
	localparam logic [7:0] ADDR_MIN     = 8'h82;
	localparam logic [7:0] ADDR_HOUR    = 8'h84;
	localparam logic [7:0] ADDR_DAY     = 8'h86;
	localparam logic [7:0] ADDR_MON     = 8'h88;
	localparam logic [7:0] ADDR_WDAY    = 8'h8a;
	localparam logic [7:0] ADDR_YEAR    = 8'h8c;

	localparam logic [7:0] PROT_OFF = 8'h00;
	localparam logic [7:0] PROT_ON  = 8'h80;
	localparam logic [7:0] HALT_BIT = 8'h80;

	localparam logic [1:0] BEAT_UNPROT = 2'd0;
	localparam logic [1:0] BEAT_VALUE  = 2'd1;
	localparam logic [1:0] BEAT_PROT   = 2'd2;

	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] wday;
		logic [7:0] hour;
		logic [7:0] min;
		logic [7:0] sec;
	} vals_t;

	typedef struct packed {
		logic       wr;
		logic [7:0] addr;
		logic [7:0] data;
		logic [3:0] mode;
		vals_t      vals;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] bcd_to_dec(input logic [7:0] v);
		return 8'(8'({4'b0, v[7:4]}) * 8'd10) + {4'b0, v[3:0]};
	endfunction

	function automatic logic [7:0] dec_to_bcd(input logic [7:0] v);
		logic [15:0] p;
		logic [7:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd205;
		q = 8'(p >> 11);
		r = v - 8'(q * 8'd10);
		return {q[3:0], 4'b0000} + r;
	endfunction

endpackage

/* design/ctsc_front.sv */
// Front end: holds mode and time values, classifies each item and builds its queue entry.
// Depends on ctsc_pkg.
module ctsc_front import ctsc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [1:0]   kind,
	input  logic [55:0]  readings,
	output entry_t       ent
);

	logic [3:0] mode_q;
	vals_t      vals_q;
	logic [3:0] nxt_mode;
	logic [3:0] m1;
	vals_t      nxt_vals;
	logic       fld_ok;
	logic [7:0] fld_addr;
	logic [7:0] fld_top;
	logic [7:0] fld_bot;
	logic [7:0] cur;
	logic [7:0] newv;

	always_comb begin
		fld_ok   = 1'b1;
		fld_addr = '0;
		fld_top  = '0;
		fld_bot  = '0;
		cur      = '0;
		unique case (mode_q)
			MODE_SEC: begin
				fld_addr = ADDR_SEC;  fld_top = 8'd59; fld_bot = 8'd0; cur = vals_q.sec;
			end
			MODE_MIN: begin
				fld_addr = ADDR_MIN;  fld_top = 8'd59; fld_bot = 8'd0; cur = vals_q.min;
			end
			MODE_HOUR: begin
				fld_addr = ADDR_HOUR; fld_top = 8'd23; fld_bot = 8'd0; cur = vals_q.hour;
			end
			MODE_WDAY: begin
				fld_addr = ADDR_WDAY; fld_top = 8'd7;  fld_bot = 8'd1; cur = vals_q.wday;
			end
			MODE_DAY: begin
				fld_addr = ADDR_DAY;  fld_top = 8'd31; fld_bot = 8'd1; cur = vals_q.day;
			end
			MODE_MON: begin
				fld_addr = ADDR_MON;  fld_top = 8'd12; fld_bot = 8'd1; cur = vals_q.month;
			end
			MODE_YEAR: begin
				fld_addr = ADDR_YEAR; fld_top = 8'd99; fld_bot = 8'd0; cur = vals_q.year;
			end
			default: fld_ok = 1'b0;
		endcase
	end

	always_comb begin
		newv = cur + 8'd1;
		if (kind == KIND_UP) begin
			if (newv == fld_top + 8'd1) newv = fld_bot;
		end else begin
			if (cur == fld_bot) newv = fld_top;
			else newv = cur - 8'd1;
		end
	end

	always_comb begin
		nxt_mode = mode_q;
		nxt_vals = vals_q;
		m1       = mode_q + 4'd1;
		ent.wr   = 1'b0;
		ent.addr = '0;
		ent.data = '0;
		unique case (kind)
			KIND_REFRESH: begin
				if (mode_q == MODE_RUN || mode_q == MODE_DONE) begin
					nxt_vals.sec   = bcd_to_dec(readings[7:0]);
					nxt_vals.min   = bcd_to_dec(readings[15:8]);
					nxt_vals.hour  = bcd_to_dec(readings[23:16]);
					nxt_vals.day   = bcd_to_dec(readings[31:24]);
					nxt_vals.month = bcd_to_dec(readings[39:32]);
					nxt_vals.year  = bcd_to_dec(readings[47:40]);
					nxt_vals.wday  = bcd_to_dec(readings[55:48]);
				end
			end
			KIND_SET: begin
				if (m1 > MODE_DONE) m1 = MODE_SEC;
				nxt_mode = m1;
				if (m1 == MODE_SEC) begin
					ent.wr   = 1'b1;
					ent.addr = ADDR_SEC;
					ent.data = HALT_BIT | dec_to_bcd(vals_q.sec);
				end else if (m1 == MODE_DONE) begin
					ent.wr   = 1'b1;
					ent.addr = ADDR_SEC;
					ent.data = dec_to_bcd(vals_q.sec) & ~HALT_BIT;
				end
			end
			default: begin
				if (fld_ok) begin
					ent.wr   = 1'b1;
					ent.addr = fld_addr;
					ent.data = dec_to_bcd(newv);
					unique case (mode_q)
						MODE_SEC:  nxt_vals.sec   = newv;
						MODE_MIN:  nxt_vals.min   = newv;
						MODE_HOUR: nxt_vals.hour  = newv;
						MODE_WDAY: nxt_vals.wday  = newv;
						MODE_DAY:  nxt_vals.day   = newv;
						MODE_MON:  nxt_vals.month = newv;
						default:   nxt_vals.year  = newv;
					endcase
				end
			end
		endcase
		ent.mode = nxt_mode;
		ent.vals = nxt_vals;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RUN;
			vals_q <= '0;
		end else if (push) begin
			mode_q <= nxt_mode;
			vals_q <= nxt_vals;
		end
	end

endmodule

/* design/ctsc_queue.sv */
// Short FIFO of classified entries between front end and write sequencer.
// Depends on ctsc_pkg.
module ctsc_queue import ctsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_ent,
	input  logic   pop,
	output entry_t head,
	output qstat_t stat
);

	entry_t          mem_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QA_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* design/ctsc_back.sv */
// Back end: maps an entry to RTC writes (unprotect, value, protect) or one status result.
// Depends on ctsc_pkg.
module ctsc_back import ctsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  qstat_t stat,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output logic   out_wr,
	output logic   out_last,
	output logic [7:0] out_addr,
	output logic [7:0] out_data,
	output logic [3:0] out_mode,
	output vals_t  out_vals
);

	logic [1:0] beat_q;
	logic       xfer;

	assign out_valid = !stat.empty;
	assign xfer      = out_valid && out_ready;
	assign out_wr    = head.wr;
	assign out_last  = !head.wr || (beat_q == BEAT_PROT);
	assign pop       = xfer && out_last;
	assign out_mode  = head.mode;
	assign out_vals  = head.vals;

	always_comb begin
		out_addr = '0;
		out_data = '0;
		if (head.wr) begin
			unique case (beat_q)
				BEAT_UNPROT: begin out_addr = ADDR_PROTECT; out_data = PROT_OFF; end
				BEAT_VALUE:  begin out_addr = head.addr;    out_data = head.data; end
				default:     begin out_addr = ADDR_PROTECT; out_data = PROT_ON;  end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= BEAT_UNPROT;
		end else if (xfer) begin
			beat_q <= out_last ? BEAT_UNPROT : beat_q + 2'd1;
		end
	end

endmodule

/* design/clock_time_setting_controller.sv */
// Top level of the clock time-setting controller: front end, entry FIFO, write sequencer.
// Depends on ctsc_pkg, ctsc_front, ctsc_queue, ctsc_back.
//
// Usage:
//  Slave channel s_*: one item per transfer. s_tuser = kind (refresh, set, up, down);
//  s_tdata = seven raw BCD bytes read from the RTC (used by refresh only).
//  Master channel m_*: one RTC write (or one status-only result) per transfer.
//  m_tuser = write_valid; m_tlast marks the final result of an item.
//  An item that changes the clock gives three transfers: unprotect, value, protect.
//  Any other item gives one transfer with write_valid low.
//  Every result carries the mode and the seven decimal time values after the item.
//  An accepted item is registered into the FIFO before its first result shows on m_*.
//  Throughput: the front end takes one item per cycle, while the FIFO is not full, into a
//  4-entry FIFO; the write sequencer drains one transfer per cycle while m_tready is high,
//  so a writing item takes three transfers and a non-writing item one.
//  Receiver stall: results hold on m_*; s_tready stays high until the FIFO fills.
//  Reset: mode returns to running, all time values to zero, the FIFO empties.
module clock_time_setting_controller import ctsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // second, minute, hour, day, month, year, weekday readings
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // rtc_address, rtc_data, mode_now, seconds, minutes,
	                              // hours, weekday, day, month, year, zero pad
	output logic        m_tuser,  // write_valid
	output logic        m_tlast
);

	entry_t     ent;
	entry_t     head;
	qstat_t     stat;
	logic       push;
	logic       pop;
	logic [7:0] out_addr;
	logic [7:0] out_data;
	logic [3:0] out_mode;
	vals_t      out_vals;

	assign s_tready = !stat.full;
	assign push     = s_tvalid && s_tready;

	ctsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.kind     (s_tuser),
		.readings (s_tdata),
		.ent      (ent)
	);

	ctsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (ent),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	ctsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_wr    (m_tuser),
		.out_last  (m_tlast),
		.out_addr  (out_addr),
		.out_data  (out_data),
		.out_mode  (out_mode),
		.out_vals  (out_vals)
	);

	assign m_tdata = {4'b0000, out_vals.year, out_vals.month, out_vals.day, out_vals.wday,
		out_vals.hour, out_vals.min, out_vals.sec, out_mode, out_data, out_addr};

`ifndef NO_ASSERTIONS
	a_nowrite_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("status-only result not marked last");

	a_last_protects: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> out_addr == ADDR_PROTECT && out_data == PROT_ON)
		else $error("write sequence does not end with protect");

	a_beat_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast && out_addr == ADDR_PROTECT
		|=> m_tvalid && m_tuser && !m_tlast)
		else $error("unprotect not followed by value write");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_mode <= MODE_DONE)
		else $error("mode out of range");
`endif

endmodule
